@@ design/cft_pkg.sv @@
// ----------------------------------------------------------------------------
// cft_pkg
// shared types, widths and codes of the cascaded first-order tilt filter
// ----------------------------------------------------------------------------
package cft_pkg;

	localparam int WORD_BITS     = 32;
	localparam int SAMPLE_BITS   = 24;
	localparam int COEF_BITS     = 32;
	localparam int LEVEL_BITS    = 19;
	localparam int COUNT_BITS    = 6;
	localparam int CHAN_BITS     = 3;
	localparam int SECIDX_BITS   = 5;
	localparam int COEF_FRAC     = COEF_BITS - 4;
	localparam int LEVEL_FRAC    = 16;
	localparam int PROD_BITS     = 2 * WORD_BITS;
	localparam int ACC_BITS      = PROD_BITS + 2;
	localparam int IN_DATA_BITS  = 72;
	localparam int OUT_DATA_BITS = 32;
	localparam int CFG_DATA_BITS = LEVEL_BITS;

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_LOAD   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		COEF_G  = 2'd0,
		COEF_A1 = 2'd1,
		COEF_B0 = 2'd2,
		COEF_B1 = 2'd3
	} coef_sel_t;

	typedef enum logic {
		CFG_INPUT_LEVEL   = 1'b0,
		CFG_SECTION_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	typedef enum logic [1:0] {
		RND_ACC   = 2'd0,
		RND_GAIN  = 2'd1,
		RND_LEVEL = 2'd2
	} rnd_src_t;

	typedef struct packed {
		logic     mul_en;
		acc_op_t  acc_op;
		logic     rnd_en;
		rnd_src_t rnd_src;
	} mac_ctrl_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCALE,
		ST_READ,
		ST_MUL_B0,
		ST_MUL_B1,
		ST_MUL_A1,
		ST_ACC_END,
		ST_ROUND,
		ST_GAIN,
		ST_GAIN_ROUND,
		ST_OUT
	} state_t;

endpackage

@@ design/cft_mac.sv @@
// ----------------------------------------------------------------------------
// cft_mac
// shared 32x32 multiplier with accumulator and round/saturate to a 32-bit word
// ----------------------------------------------------------------------------
module cft_mac (
	input  logic              clk,
	input  cft_pkg::mac_ctrl_t ctrl,
	input  cft_pkg::word_t    mul_a,
	input  cft_pkg::word_t    mul_b,
	output cft_pkg::word_t    word
);

	localparam int AB = cft_pkg::ACC_BITS;
	localparam logic signed [AB-1:0] HALF_COEF  = AB'(1) << (cft_pkg::COEF_FRAC - 1);
	localparam logic signed [AB-1:0] HALF_LEVEL = AB'(1) << (cft_pkg::LEVEL_FRAC - 1);
	localparam logic signed [AB-1:0] W_MAX = (AB'(1) << (cft_pkg::WORD_BITS - 1)) - AB'(1);
	localparam logic signed [AB-1:0] W_MIN = -(AB'(1) << (cft_pkg::WORD_BITS - 1));

	logic signed [cft_pkg::PROD_BITS-1:0] prod;
	logic signed [cft_pkg::PROD_BITS-1:0] prod_q;
	logic signed [AB-1:0]                 prod_ext;
	logic signed [AB-1:0]                 acc_q;
	logic signed [AB-1:0]                 src;
	logic signed [AB-1:0]                 biased;
	logic signed [AB-1:0]                 shifted;
	cft_pkg::word_t                       rounded;
	cft_pkg::word_t                       word_q;

	assign prod     = mul_a * mul_b;
	assign prod_ext = AB'(prod_q);

	always_comb begin
		case (ctrl.rnd_src)
			cft_pkg::RND_ACC: src = acc_q;
			default:          src = prod_ext;
		endcase
		if (ctrl.rnd_src == cft_pkg::RND_LEVEL) begin
			biased  = src + HALF_LEVEL;
			shifted = biased >>> cft_pkg::LEVEL_FRAC;
		end else begin
			biased  = src + HALF_COEF;
			shifted = biased >>> cft_pkg::COEF_FRAC;
		end
		if (shifted > W_MAX) begin
			rounded = cft_pkg::word_t'(W_MAX);
		end else if (shifted < W_MIN) begin
			rounded = cft_pkg::word_t'(W_MIN);
		end else begin
			rounded = cft_pkg::word_t'(shifted);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= prod;
		end
		case (ctrl.acc_op)
			cft_pkg::ACC_LOAD: acc_q <= prod_ext;
			cft_pkg::ACC_ADD:  acc_q <= acc_q + prod_ext;
			cft_pkg::ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:           acc_q <= acc_q;
		endcase
		if (ctrl.rnd_en) begin
			word_q <= rounded;
		end
	end

	assign word = word_q;

endmodule

@@ design/cascaded_first_order_tilt_filter.sv @@
// ----------------------------------------------------------------------------
// cascaded_first_order_tilt_filter
// Spectral-tilt filter: an input item either loads one coefficient word (g,
// a1, b0 or b1 of one section) or filters one sample of one channel through
// section_count first-order sections in series. After a load the block stays
// idle and ready for the next item. A sample is first scaled by the input
// level; each section in use then runs the states READ, MUL_B0, MUL_B1,
// MUL_A1, ACC_END, ROUND, GAIN and GAIN_ROUND, and ST_OUT loads the output
// register. The next item is taken after that, or later while an earlier
// result still waits in the output register. All products go through one
// shared 32x32 multiplier, and each section makes four passes through it,
// each fed by one read of the coefficient memory. Per-channel section history
// lives in a synchronous memory that is cleared after reset by a pass over
// its NUM_CHANNELS*MAX_SECTIONS rows, both rounded up to powers of two
// (256 rows by default); no item is accepted during that pass, while
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module cascaded_first_order_tilt_filter #(
	parameter int MAX_SECTIONS = 32,
	parameter int NUM_CHANNELS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// channel, sample_in, section_index, coef_select, coef_value, zero fill
	input  logic [cft_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// operation
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// channel_out, sample_out, zero fill
	output logic [cft_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_index,
	input  logic [cft_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int SEC_W      = $clog2(MAX_SECTIONS);
	localparam int CNT_W      = $clog2(MAX_SECTIONS + 1);
	localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CA_W       = SEC_W + 2;
	localparam int COEF_DEPTH = MAX_SECTIONS * 4;
	localparam int HA_W       = CH_W + SEC_W;
	localparam int HIST_DEPTH = 1 << HA_W;
	localparam int IDX_W      = 7;
	localparam int WB         = cft_pkg::WORD_BITS;
	localparam int SB         = cft_pkg::SAMPLE_BITS;
	localparam logic signed [WB-1:0] OUT_MAX = WB'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [WB-1:0] OUT_MIN = WB'(-(64'sd1 <<< (SB - 1)));

	// input fields
	logic [cft_pkg::CHAN_BITS-1:0]   in_channel;
	logic signed [SB-1:0]            in_sample;
	logic [cft_pkg::SECIDX_BITS-1:0] in_section;
	logic [1:0]                      in_sel;
	logic [cft_pkg::COEF_BITS-1:0]   in_coef;
	cft_pkg::op_t                    in_op;

	assign in_channel = s_tdata[2:0];
	assign in_sample  = s_tdata[26:3];
	assign in_section = s_tdata[31:27];
	assign in_sel     = s_tdata[33:32];
	assign in_coef    = s_tdata[65:34];
	assign in_op      = cft_pkg::op_t'(s_tuser[0]);

	// configuration
	logic [cft_pkg::LEVEL_BITS-1:0] level_q;
	logic [cft_pkg::COUNT_BITS-1:0] count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= cft_pkg::LEVEL_BITS'(65536);
			count_q <= cft_pkg::COUNT_BITS'(5);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cft_pkg::cfg_idx_t'(cfg_index))
				cft_pkg::CFG_INPUT_LEVEL:   level_q <= cfg_data[cft_pkg::LEVEL_BITS-1:0];
				cft_pkg::CFG_SECTION_COUNT: count_q <= cfg_data[cft_pkg::COUNT_BITS-1:0];
			endcase
		end
	end

	// state and control
	cft_pkg::state_t    state_q, state_d;
	cft_pkg::mac_ctrl_t ctrl;
	cft_pkg::coef_sel_t coef_sel;
	cft_pkg::word_t     mul_a, mul_b, word;
	logic               coef_rd, hist_rd, hist_wr, out_load;
	logic [HA_W-1:0]    clr_q;
	logic [CNT_W-1:0]   sec_q, n_q, sec_nxt;
	logic [IDX_W-1:0]   ch_wide, sec_wide, cnt_wide, n_wide;
	logic               ch_ok, sec_ok, in_fire;

	// payload
	logic [cft_pkg::CHAN_BITS-1:0] chan_q;
	logic [IDX_W-1:0]              chan_wide;
	cft_pkg::word_t                x_q;
	cft_pkg::word_t                cdat_q;
	logic [2*WB-1:0]               hist_q;
	logic [CA_W-1:0]               coef_raddr, coef_waddr;
	logic [HA_W-1:0]               hist_addr, hist_waddr;
	logic [2*WB-1:0]               hist_wdata;
	logic signed [WB-1:0]          out_sat;

	logic [cft_pkg::COEF_BITS-1:0] coef_mem [COEF_DEPTH];
	logic [2*WB-1:0]               hist_mem [HIST_DEPTH];

	assign in_fire   = s_tvalid && s_tready;
	assign ch_wide   = IDX_W'(in_channel);
	assign sec_wide  = IDX_W'(in_section);
	assign cnt_wide  = IDX_W'(count_q);
	assign chan_wide = IDX_W'(chan_q);
	assign ch_ok     = ch_wide < IDX_W'(NUM_CHANNELS);
	assign sec_ok    = sec_wide < IDX_W'(MAX_SECTIONS);
	assign n_wide    = (cnt_wide > IDX_W'(MAX_SECTIONS)) ? IDX_W'(MAX_SECTIONS) : cnt_wide;
	assign sec_nxt   = sec_q + CNT_W'(1);

	assign coef_waddr = {sec_wide[SEC_W-1:0], in_sel};
	assign coef_raddr = {sec_q[SEC_W-1:0], coef_sel};
	assign hist_addr  = {chan_wide[CH_W-1:0], sec_q[SEC_W-1:0]};
	assign hist_waddr = (state_q == cft_pkg::ST_CLEAR) ? clr_q : hist_addr;
	assign hist_wdata = (state_q == cft_pkg::ST_CLEAR) ? '0 : {word, x_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cft_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		mul_a    = x_q;
		mul_b    = cdat_q;
		coef_rd  = 1'b0;
		coef_sel = cft_pkg::COEF_B0;
		hist_rd  = 1'b0;
		hist_wr  = 1'b0;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			cft_pkg::ST_CLEAR: begin
				hist_wr = 1'b1;
				if (clr_q == '1) begin
					state_d = cft_pkg::ST_IDLE;
				end
			end
			cft_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && in_op == cft_pkg::OP_SAMPLE && ch_ok) begin
					ctrl.mul_en = 1'b1;
					mul_a       = WB'(in_sample);
					mul_b       = WB'($unsigned(level_q));
					state_d     = cft_pkg::ST_SCALE;
				end
			end
			cft_pkg::ST_SCALE: begin
				ctrl.rnd_en  = 1'b1;
				ctrl.rnd_src = cft_pkg::RND_LEVEL;
				state_d      = (n_q == '0) ? cft_pkg::ST_OUT : cft_pkg::ST_READ;
			end
			cft_pkg::ST_READ: begin
				coef_rd  = 1'b1;
				coef_sel = cft_pkg::COEF_B0;
				hist_rd  = 1'b1;
				state_d  = cft_pkg::ST_MUL_B0;
			end
			cft_pkg::ST_MUL_B0: begin
				ctrl.mul_en = 1'b1;
				coef_rd     = 1'b1;
				coef_sel    = cft_pkg::COEF_B1;
				state_d     = cft_pkg::ST_MUL_B1;
			end
			cft_pkg::ST_MUL_B1: begin
				ctrl.acc_op = cft_pkg::ACC_LOAD;
				ctrl.mul_en = 1'b1;
				mul_a       = hist_q[WB-1:0];
				coef_rd     = 1'b1;
				coef_sel    = cft_pkg::COEF_A1;
				state_d     = cft_pkg::ST_MUL_A1;
			end
			cft_pkg::ST_MUL_A1: begin
				ctrl.acc_op = cft_pkg::ACC_ADD;
				ctrl.mul_en = 1'b1;
				mul_a       = hist_q[2*WB-1:WB];
				coef_rd     = 1'b1;
				coef_sel    = cft_pkg::COEF_G;
				state_d     = cft_pkg::ST_ACC_END;
			end
			cft_pkg::ST_ACC_END: begin
				ctrl.acc_op = cft_pkg::ACC_SUB;
				state_d     = cft_pkg::ST_ROUND;
			end
			cft_pkg::ST_ROUND: begin
				ctrl.rnd_en  = 1'b1;
				ctrl.rnd_src = cft_pkg::RND_ACC;
				state_d      = cft_pkg::ST_GAIN;
			end
			cft_pkg::ST_GAIN: begin
				ctrl.mul_en = 1'b1;
				mul_a       = word;
				hist_wr     = 1'b1;
				state_d     = cft_pkg::ST_GAIN_ROUND;
			end
			cft_pkg::ST_GAIN_ROUND: begin
				ctrl.rnd_en  = 1'b1;
				ctrl.rnd_src = cft_pkg::RND_GAIN;
				state_d      = (sec_nxt == n_q) ? cft_pkg::ST_OUT : cft_pkg::ST_READ;
			end
			cft_pkg::ST_OUT: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d  = cft_pkg::ST_IDLE;
				end
			end
			default: state_d = cft_pkg::ST_IDLE;
		endcase
	end

	cft_mac u_mac (
		.clk   (clk),
		.ctrl  (ctrl),
		.mul_a (mul_a),
		.mul_b (mul_b),
		.word  (word)
	);

	// control counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			sec_q    <= '0;
			n_q      <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (state_q == cft_pkg::ST_CLEAR) begin
				clr_q <= clr_q + HA_W'(1);
			end
			if (in_fire && in_op == cft_pkg::OP_SAMPLE) begin
				sec_q <= '0;
				n_q   <= n_wide[CNT_W-1:0];
			end else if (state_q == cft_pkg::ST_GAIN_ROUND) begin
				sec_q <= sec_nxt;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// final saturation to the sample width
	always_comb begin
		if (word > OUT_MAX) begin
			out_sat = OUT_MAX;
		end else if (word < OUT_MIN) begin
			out_sat = OUT_MIN;
		end else begin
			out_sat = word;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			chan_q <= in_channel;
		end
		if (state_q == cft_pkg::ST_READ) begin
			x_q <= word;
		end
		if (out_load) begin
			m_tdata <= cft_pkg::OUT_DATA_BITS'({out_sat[SB-1:0], chan_q});
		end
	end

	// coefficient memory
	always_ff @(posedge clk) begin
		if (in_fire && in_op == cft_pkg::OP_LOAD && sec_ok) begin
			coef_mem[coef_waddr] <= in_coef;
		end
		if (coef_rd) begin
			cdat_q <= coef_mem[coef_raddr];
		end
	end

	// section history memory, {y, x} per row
	always_ff @(posedge clk) begin
		if (hist_wr) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		if (hist_rd) begin
			hist_q <= hist_mem[hist_addr];
		end
	end

endmodule

@@ sim/tilt_filter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tilt_filter_checker
// Watches the sample, result and register channels of the tilt filter. It
// keeps its own copy of the coefficients, the per-channel section history and
// the two registers, works out each filtered sample when the item is taken,
// and compares every result that leaves the block against the oldest one
// still owed.
// ----------------------------------------------------------------------------
module tilt_filter_checker
	import cft_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [IN_DATA_BITS-1:0]   s_tdata,
	input  logic [0:0]                s_tuser,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [OUT_DATA_BITS-1:0]  m_tdata,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [0:0]                cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        pending_results,
	output int                        mismatches
);

	localparam int N_SEC = 32;
	localparam int N_CH  = 8;

	typedef struct {
		logic [CHAN_BITS-1:0]          chan;
		logic signed [SAMPLE_BITS-1:0] smp;
	} tilt_out_t;

	word_t                 coef_mem [0:N_SEC*4-1];
	word_t                 hist_x [0:N_CH-1][0:N_SEC-1];
	word_t                 hist_y [0:N_CH-1][0:N_SEC-1];
	logic [LEVEL_BITS-1:0] level;
	logic [COUNT_BITS-1:0] sections;
	tilt_out_t             expected_out [$];
	tilt_out_t             want;

	task automatic flag(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic word_t sat_word(input logic signed [79:0] v);
		if (v > 80'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -80'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// round half up out of Q4.28 products, back to a Q9.23 word
	function automatic word_t round_q23(input logic signed [79:0] acc);
		return sat_word((acc + (80'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
		input logic [CHAN_BITS-1:0] ch,
		input logic signed [SAMPLE_BITS-1:0] smp
	);
		logic signed [79:0] acc;
		word_t              x;
		word_t              y;
		int                 n;
		int                 base;
		acc = 80'(smp) * $signed({1'b0, level});
		x = sat_word((acc + 80'sd32768) >>> LEVEL_FRAC);
		n = (sections > N_SEC) ? N_SEC : int'(sections);
		for (int b = 0; b < n; b++) begin
			base = b * 4;
			acc = 80'(x) * 80'(coef_mem[base + int'(COEF_B0)])
				+ 80'(hist_x[ch][b]) * 80'(coef_mem[base + int'(COEF_B1)])
				- 80'(hist_y[ch][b]) * 80'(coef_mem[base + int'(COEF_A1)]);
			y = round_q23(acc);
			hist_x[ch][b] = x;
			hist_y[ch][b] = y;
			x = round_q23(80'(y) * 80'(coef_mem[base + int'(COEF_G)]));
		end
		if (x > 32'sd8388607)
			return 24'h7F_FFFF;
		if (x < -32'sd8388608)
			return 24'h80_0000;
		return x[SAMPLE_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (hist_x[c, b]) begin
				hist_x[c][b] = '0;
				hist_y[c][b] = '0;
			end
			foreach (coef_mem[i])
				coef_mem[i] = '0;
			level = 19'd65536;
			sections = 6'd5;
			expected_out.delete();
			mismatches = 0;
			pending_results <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					flag($sformatf("result ch %0d sample %0d with none owed",
						m_tdata[2:0], $signed(m_tdata[26:3])));
				end else begin
					want = expected_out.pop_front();
					if (m_tdata[2:0] != want.chan)
						flag($sformatf("channel_out %0d, want %0d", m_tdata[2:0], want.chan));
					if ($signed(m_tdata[26:3]) != want.smp)
						flag($sformatf("sample_out %0d, want %0d (ch %0d)",
							$signed(m_tdata[26:3]), want.smp, want.chan));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_INPUT_LEVEL:   level = cfg_data;
					CFG_SECTION_COUNT: sections = cfg_data[COUNT_BITS-1:0];
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (op_t'(s_tuser[0]) == OP_LOAD) begin
					coef_mem[{s_tdata[31:27], s_tdata[33:32]}] = s_tdata[65:34];
				end else begin
					want.chan = s_tdata[2:0];
					want.smp = filter_sample(s_tdata[2:0], s_tdata[26:3]);
					expected_out.push_back(want);
				end
			end
			pending_results <= expected_out.size();
		end
	end

endmodule

@@ sim/tb_cascaded_first_order_tilt_filter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascaded_first_order_tilt_filter
// Loads every coefficient, runs a short list of edge-case samples and loads,
// then random traffic over several level and section-count settings. The
// sender works in bursts with random gaps and the receiver stalls on a
// rotating pattern; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_cascaded_first_order_tilt_filter;
	import cft_pkg::*;

	localparam int SETTLE_CYCLES = 8 * 32 + 8;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata = '0;
	logic [0:0]               s_tuser = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [0:0]               cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	int                       pending_results;
	int                       mismatches;
	int                       burst_left = 0;
	logic [15:0]              stall_cyc = '0;

	cascaded_first_order_tilt_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tilt_filter_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pending_results (pending_results),
		.mismatches      (mismatches)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: free running, random, long periodic stalls, toggling
	always @(posedge clk) begin
		stall_cyc <= stall_cyc + 16'd1;
		case (stall_cyc[10:9])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= (stall_cyc[4:0] < 5'd6);
			default: m_tready <= stall_cyc[2] ^ stall_cyc[0];
		endcase
	end

	function automatic logic [IN_DATA_BITS-1:0] pack_item(
		input logic [CHAN_BITS-1:0]   ch,
		input logic [SAMPLE_BITS-1:0] smp,
		input logic [SECIDX_BITS-1:0] sec,
		input coef_sel_t              sel,
		input logic [COEF_BITS-1:0]   val
	);
		return {6'd0, val, sel, sec, smp, ch};
	endfunction

	function automatic logic [COEF_BITS-1:0] make_coef(input coef_sel_t sel);
		logic signed [31:0] unit_off;
		unit_off = $signed(32'($urandom_range(0, 32'h1FFF_FFFF))) - 32'sh1000_0000;
		if ($urandom_range(0, 31) == 0)
			return $urandom;
		case (sel)
			COEF_G:  return 32'sh1000_0000 + (unit_off >>> 3);
			COEF_A1: return unit_off - (unit_off >>> 4);
			default: return unit_off >>> 1;
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] make_sample();
		case ($urandom_range(0, 7))
			0: return 24'h7F_FFFF;
			1: return 24'h80_0000;
			2, 3: return 24'($urandom_range(0, 4095) - 2048);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic feed_item(input op_t op, input logic [IN_DATA_BITS-1:0] data);
		s_tuser <= op;
		s_tdata <= data;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(50, 300)) @(posedge clk);
			else
				repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
				: $urandom_range(0, 6);
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [IN_DATA_BITS-1:0] sample_item(
		input logic [CHAN_BITS-1:0]   ch,
		input logic [SAMPLE_BITS-1:0] smp
	);
		return pack_item(ch, smp, 5'($urandom), coef_sel_t'($urandom_range(0, 3)), $urandom);
	endfunction

	function automatic logic [IN_DATA_BITS-1:0] load_item(
		input logic [SECIDX_BITS-1:0] sec,
		input coef_sel_t              sel,
		input logic [COEF_BITS-1:0]   val
	);
		return pack_item(3'($urandom), 24'($urandom), sec, sel, val);
	endfunction

	initial begin
		int                     lvl;
		int                     cnt;
		int                     num;
		coef_sel_t              sel;
		logic [SECIDX_BITS-1:0] sec;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(CFG_INPUT_LEVEL, 19'd65536);
		write_reg(CFG_SECTION_COUNT, 19'd5);

		// every coefficient defined before the first sample
		for (int s = 0; s < 32; s++)
			for (int k = 0; k < 4; k++) begin
				sel = coef_sel_t'(k);
				feed_item(OP_LOAD, load_item(5'(s), sel, make_coef(sel)));
			end

		// full-scale and zero samples, saturating and zero coefficients
		feed_item(OP_SAMPLE, sample_item(3'd0, 24'h7F_FFFF));
		feed_item(OP_SAMPLE, sample_item(3'd0, 24'h80_0000));
		feed_item(OP_SAMPLE, sample_item(3'd7, 24'h00_0000));
		feed_item(OP_SAMPLE, sample_item(3'd7, 24'h7F_FFFF));
		feed_item(OP_SAMPLE, sample_item(3'd3, 24'hFF_FFFF));
		feed_item(OP_SAMPLE, sample_item(3'd3, 24'h00_0001));
		feed_item(OP_LOAD, load_item(5'd0, COEF_B0, 32'h7FFF_FFFF));
		feed_item(OP_SAMPLE, sample_item(3'd0, 24'h7F_FFFF));
		feed_item(OP_SAMPLE, sample_item(3'd0, 24'h80_0000));
		feed_item(OP_LOAD, load_item(5'd0, COEF_A1, 32'h8000_0000));
		feed_item(OP_SAMPLE, sample_item(3'd1, 24'h80_0000));
		feed_item(OP_SAMPLE, sample_item(3'd1, 24'h80_0000));
		feed_item(OP_LOAD, load_item(5'd31, COEF_G, 32'h8000_0000));
		feed_item(OP_LOAD, load_item(5'd4, COEF_G, 32'h0000_0000));
		feed_item(OP_SAMPLE, sample_item(3'd2, 24'h7F_FFFF));
		feed_item(OP_LOAD, load_item(5'd0, COEF_B0, make_coef(COEF_B0)));
		feed_item(OP_LOAD, load_item(5'd0, COEF_A1, make_coef(COEF_A1)));
		feed_item(OP_LOAD, load_item(5'd4, COEF_G, make_coef(COEF_G)));
		feed_item(OP_SAMPLE, sample_item(3'd2, 24'h80_0000));
		feed_item(OP_SAMPLE, sample_item(3'd5, 24'h12_3456));
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin lvl = 262144; cnt = 2; num = 300; end
				1: begin lvl = 0; cnt = 4; num = 120; end
				2: begin lvl = 65536; cnt = 3; num = 300; end
				3: begin lvl = 262144; cnt = 32; num = 120; end
				4: begin lvl = $urandom_range(0, 262144); cnt = $urandom_range(2, 32); num = 250; end
				5: begin lvl = $urandom_range(0, 65536); cnt = 2; num = 300; end
				6: begin lvl = $urandom_range(0, 262144); cnt = $urandom_range(2, 8); num = 200; end
				default: begin lvl = 32768; cnt = 8; num = 200; end
			endcase
			write_reg(CFG_INPUT_LEVEL, 19'(lvl));
			write_reg(CFG_SECTION_COUNT, 19'(cnt));
			for (int i = 0; i < num; i++) begin
				if ($urandom_range(0, 7) == 0) begin
					sel = coef_sel_t'($urandom_range(0, 3));
					sec = 5'($urandom);
					feed_item(OP_LOAD, load_item(sec, sel, make_coef(sel)));
				end else begin
					feed_item(OP_SAMPLE, sample_item(3'($urandom), make_sample()));
				end
			end
			settle();
		end

		if (mismatches == 0 && pending_results == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
design/cft_pkg.sv
design/cft_mac.sv
design/cascaded_first_order_tilt_filter.sv
sim/tilt_filter_checker.sv
sim/tb_cascaded_first_order_tilt_filter.sv
